/* design/variable_record_ring_buffer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the variable record ring buffer
// Short forms for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH
`define VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH

// same-cycle implication, off while reset is low
`define VRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vrb: property violated");

// next-cycle implication, off while reset is low
`define VRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vrb: property violated");

// what must hold in the cycle after reset was sampled low
`define VRB_ASSERT_RST(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("vrb: reset property violated");

`endif

/* design/vrb_pkg.sv */
// ----------------------------------------------------------------------------
// vrb_pkg
// Shared widths, codes and structs of the variable record ring buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrb_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int HEADER_BYTES_DEF = 2;
    localparam int MAX_RECORD_DEF   = 64;

    localparam int POS_W      = 13;   // read/write positions
    localparam int START_W    = 12;   // region_start register
    localparam int LEN_W      = 7;    // record_length field
    localparam int BYTE_W     = 8;
    localparam int HLEN_W     = 16;   // length stored in a header
    localparam int XW         = 18;   // unmasked address sums
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 1'b1;

    localparam logic [START_W-1:0] START_RST = 12'd0;
    localparam logic [POS_W-1:0]   END_RST   = 13'd4096;

    typedef enum logic [1:0] {
        CMD_WHDR  = 2'd0,
        CMD_WBYTE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BADLEN  = 2'd3
    } t_status;

    typedef struct packed {
        logic              vld;
        t_status           status;
        logic [BYTE_W-1:0] data;
        logic              dvalid;
        logic              last;
    } t_res;

    typedef struct packed {
        logic              en;
        logic [XW-1:0]     addr;
        logic [BYTE_W-1:0] data;
    } t_wr;

endpackage

/* design/vrb_mem.sv */
// ----------------------------------------------------------------------------
// vrb_mem
// Byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrb_mem #(
    parameter int DEPTH = vrb_pkg::BUFFER_BYTES_DEF
) (
    input  logic                       i_clk,
    input  vrb_pkg::t_wr               i_wr,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [vrb_pkg::BYTE_W-1:0] o_rdata
);

    localparam int IW = $clog2(DEPTH);

    logic [vrb_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [vrb_pkg::BYTE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[IW-1:0]] <= i_wr.data;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

/* design/vrb_out.sv */
// ----------------------------------------------------------------------------
// vrb_out
// Output register of the result stream; reloads when empty or while the held word is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrb_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vrb_pkg::t_res                   i_res,
    input  logic                            i_tready,
    output logic                            o_free,
    output logic                            o_tvalid,
    output logic [vrb_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic [vrb_pkg::OUT_TUSER_W-1:0] o_tuser,
    output logic                            o_tlast
);

    logic                       r_vld;
    vrb_pkg::t_status           r_status;
    logic [vrb_pkg::BYTE_W-1:0] r_data;
    logic                       r_dvalid;
    logic                       r_last;

    assign o_free = !r_vld || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.vld) begin
            r_status <= i_res.status;
            r_data   <= i_res.data;
            r_dvalid <= i_res.dvalid;
            r_last   <= i_res.last;
        end
    end

    assign o_tvalid = r_vld;
    assign o_tdata  = r_data;
    assign o_tuser  = {r_dvalid, r_status};
    assign o_tlast  = r_last;

endmodule

/* design/vrb_ctrl.sv */
// ----------------------------------------------------------------------------
// vrb_ctrl
// Sequencer: positions, space and data checks, header and payload walks
// through the byte store, and the clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrb_ctrl #(
    parameter int BUFFER_BYTES     = vrb_pkg::BUFFER_BYTES_DEF,
    parameter int HEADER_BYTES     = vrb_pkg::HEADER_BYTES_DEF,
    parameter int MAX_RECORD_BYTES = vrb_pkg::MAX_RECORD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vrb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vrb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  vrb_pkg::t_cmd                     i_cmd,
    input  logic [vrb_pkg::LEN_W-1:0]         i_len,
    input  logic [vrb_pkg::BYTE_W-1:0]        i_byte,
    input  logic                              i_out_free,
    output vrb_pkg::t_res                     o_res,
    output vrb_pkg::t_wr                      o_wr,
    output logic [$clog2(BUFFER_BYTES)-1:0]   o_raddr,
    input  logic [vrb_pkg::BYTE_W-1:0]        i_rdata
);

    localparam int IW     = $clog2(BUFFER_BYTES);
    localparam int XW     = vrb_pkg::XW;
    localparam int POS_W  = vrb_pkg::POS_W;
    localparam int LEN_W  = vrb_pkg::LEN_W;
    localparam int BYTE_W = vrb_pkg::BYTE_W;
    localparam int HLEN_W = vrb_pkg::HLEN_W;

    localparam logic [XW-1:0]     BUF_X    = XW'(BUFFER_BYTES);
    localparam logic [XW-1:0]     HDR_X    = XW'(HEADER_BYTES);
    localparam logic [HLEN_W-1:0] MAX_H    = HLEN_W'(MAX_RECORD_BYTES);
    localparam logic [LEN_W-1:0]  MAX_L    = LEN_W'(MAX_RECORD_BYTES);
    localparam logic [LEN_W-1:0]  HLAST    = LEN_W'(HEADER_BYTES - 1);
    localparam logic [IW-1:0]     CLR_LAST = IW'(BUFFER_BYTES - 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b0_0000_0001,
        S_IDLE  = 9'b0_0000_0010,
        S_WHDR  = 9'b0_0000_0100,
        S_RES   = 9'b0_0000_1000,
        S_RHA   = 9'b0_0001_0000,
        S_RHB   = 9'b0_0010_0000,
        S_RDEC  = 9'b0_0100_0000,
        S_HCLR  = 9'b0_1000_0000,
        S_RPAY  = 9'b1_0000_0000
    } t_state;

    t_state                        r_state, n_state;
    logic [IW-1:0]                 r_clr, n_clr;
    logic [vrb_pkg::START_W-1:0]   r_start;
    logic [POS_W-1:0]              r_end;
    logic [POS_W-1:0]              r_rpos, n_rpos;
    logic [POS_W-1:0]              r_wpos, n_wpos;
    logic                          r_flag, n_flag;
    logic [LEN_W-1:0]              r_left, n_left;
    logic                          r_wacc, n_wacc;
    logic [XW-1:0]                 r_base, n_base;
    logic [LEN_W-1:0]              r_cnt, n_cnt;
    logic [HLEN_W-1:0]             r_len, n_len;
    logic [XW-1:0]                 r_raddr, n_raddr;
    logic                          r_phase, n_phase;
    vrb_pkg::t_status              r_res_st, n_res_st;

    logic [XW-1:0]     w_x, r_x, start_x, end_x, size_x;
    logic [XW-1:0]     ws_base, pw_x, rec_end, wa_x;
    logic              ws_ahead, ws_fit_end, ws_wrap, ws_ok, len_bad;
    logic              fd_cond, fd_hdr_in, w_gt_r, w_gt_s, rec_ok, in_acc;
    logic [BYTE_W-1:0] rd_q;

    assign w_x     = XW'(r_wpos);
    assign r_x     = XW'(r_rpos);
    assign start_x = XW'(r_start);
    assign end_x   = XW'(r_end);
    assign size_x  = XW'(i_len) + HDR_X;

    // space check for a new record, with the wrap to region start
    assign ws_ahead   = (w_x > r_x) || (r_flag && (w_x == r_x));
    assign ws_fit_end = (w_x + size_x) <= end_x;
    assign ws_wrap    = ws_ahead && !ws_fit_end;
    assign ws_base    = ws_wrap ? start_x : w_x;
    assign ws_ok      = (ws_ahead && ws_fit_end) ||
                        ((ws_base < r_x) && ((ws_base + size_x) <= r_x));
    assign len_bad    = (i_len == '0) || (i_len > MAX_L);

    assign pw_x = XW'(POS_W'(r_wpos - POS_W'(r_left)));

    // data check for a read
    assign fd_cond   = (w_x < r_x) || (!r_flag && (w_x == r_x));
    assign fd_hdr_in = (r_x + HDR_X) < end_x;
    assign w_gt_r    = w_x > r_x;
    assign w_gt_s    = w_x > start_x;
    assign rec_end   = r_x + HDR_X + XW'(r_len);
    assign rec_ok    = (r_len != '0) && (rec_end <= end_x);

    assign wa_x = r_base + XW'(r_cnt);

    // positions past the store read as zero
    assign rd_q = (r_raddr < BUF_X) ? i_rdata : '0;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_raddr    = n_raddr[IW-1:0];

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_rpos   = r_rpos;
        n_wpos   = r_wpos;
        n_flag   = r_flag;
        n_left   = r_left;
        n_wacc   = r_wacc;
        n_base   = r_base;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_raddr  = r_raddr;
        n_phase  = r_phase;
        n_res_st = r_res_st;

        o_wr.en       = 1'b0;
        o_wr.addr     = wa_x;
        o_wr.data     = '0;
        o_res.vld     = 1'b0;
        o_res.status  = vrb_pkg::ST_OK;
        o_res.data    = '0;
        o_res.dvalid  = 1'b0;
        o_res.last    = 1'b1;

        case (r_state)
            S_CLEAR: begin
                o_wr.en   = 1'b1;
                o_wr.addr = XW'(r_clr);
                n_clr     = r_clr + IW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_acc) begin
                    case (i_cmd)
                        vrb_pkg::CMD_WHDR: begin
                            n_wacc = 1'b0;
                            n_left = '0;
                            if (len_bad) begin
                                n_res_st = vrb_pkg::ST_BADLEN;
                                n_state  = S_RES;
                            end else begin
                                if (ws_wrap) begin
                                    n_flag = !r_flag;
                                    n_wpos = POS_W'(r_start);
                                end
                                if (ws_ok) begin
                                    // reserve the whole record now
                                    n_base  = ws_base;
                                    n_wpos  = POS_W'(ws_base + size_x);
                                    n_wacc  = 1'b1;
                                    n_left  = i_len;
                                    n_cnt   = '0;
                                    n_state = S_WHDR;
                                end else begin
                                    n_res_st = vrb_pkg::ST_NOSPACE;
                                    n_state  = S_RES;
                                end
                            end
                        end

                        vrb_pkg::CMD_WBYTE: begin
                            if (!r_wacc || (r_left == '0)) begin
                                n_wacc   = 1'b0;
                                n_left   = '0;
                                n_res_st = vrb_pkg::ST_NOSPACE;
                            end else begin
                                o_wr.en   = pw_x < BUF_X;
                                o_wr.addr = pw_x;
                                o_wr.data = i_byte;
                                n_left    = r_left - LEN_W'(1);
                                n_wacc    = (r_left != LEN_W'(1));
                                n_res_st  = vrb_pkg::ST_OK;
                            end
                            n_state = S_RES;
                        end

                        vrb_pkg::CMD_READ: begin
                            n_wacc = 1'b0;
                            n_left = '0;
                            if (fd_cond && fd_hdr_in) begin
                                n_raddr = r_x;
                                n_phase = 1'b0;
                                n_state = S_RHA;
                            end else if (fd_cond) begin
                                // no room for a header before the end: wrap
                                n_rpos = POS_W'(r_start);
                                n_flag = !r_flag;
                                if (w_gt_s) begin
                                    n_raddr = start_x;
                                    n_phase = 1'b1;
                                    n_state = S_RHA;
                                end else begin
                                    n_res_st = vrb_pkg::ST_EMPTY;
                                    n_state  = S_RES;
                                end
                            end else if (w_gt_r) begin
                                n_raddr = r_x;
                                n_phase = 1'b1;
                                n_state = S_RHA;
                            end else begin
                                n_res_st = vrb_pkg::ST_EMPTY;
                                n_state  = S_RES;
                            end
                        end

                        default: begin
                            // drop the word, no result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_WHDR: begin
                o_wr.en   = wa_x < BUF_X;
                o_wr.addr = wa_x;
                o_wr.data = (r_cnt == '0) ? BYTE_W'(r_left) : '0;
                if (r_cnt == HLAST) begin
                    n_res_st = vrb_pkg::ST_OK;
                    n_state  = S_RES;
                end else begin
                    n_cnt = r_cnt + LEN_W'(1);
                end
            end

            S_RES: begin
                if (i_out_free) begin
                    o_res.vld    = 1'b1;
                    o_res.status = r_res_st;
                    n_state      = S_IDLE;
                end
            end

            S_RHA: begin
                n_len = {8'h00, rd_q};
                if (HEADER_BYTES >= 2) begin
                    n_raddr = r_raddr + XW'(1);
                    n_state = S_RHB;
                end else begin
                    n_state = S_RDEC;
                end
            end

            S_RHB: begin
                n_len   = {rd_q, r_len[7:0]};
                n_state = S_RDEC;
            end

            S_RDEC: begin
                if (!r_phase && !rec_ok) begin
                    // zero or overrunning header: wrap and look again
                    n_rpos = POS_W'(r_start);
                    n_flag = !r_flag;
                    if (w_gt_s) begin
                        n_raddr = start_x;
                        n_phase = 1'b1;
                        n_state = S_RHA;
                    end else begin
                        n_res_st = vrb_pkg::ST_EMPTY;
                        n_state  = S_RES;
                    end
                end else if (r_len > MAX_H) begin
                    n_res_st = vrb_pkg::ST_BADLEN;
                    n_state  = S_RES;
                end else begin
                    n_base  = r_x;
                    n_rpos  = POS_W'(rec_end);
                    n_cnt   = '0;
                    n_state = S_HCLR;
                end
            end

            S_HCLR: begin
                o_wr.en   = wa_x < BUF_X;
                o_wr.addr = wa_x;
                if (r_cnt == HLAST) begin
                    if (r_len == '0) begin
                        n_res_st = vrb_pkg::ST_OK;
                        n_state  = S_RES;
                    end else begin
                        n_cnt   = '0;
                        n_raddr = r_base + HDR_X;
                        n_state = S_RPAY;
                    end
                end else begin
                    n_cnt = r_cnt + LEN_W'(1);
                end
            end

            S_RPAY: begin
                if (i_out_free) begin
                    o_res.vld    = 1'b1;
                    o_res.data   = rd_q;
                    o_res.dvalid = 1'b1;
                    o_res.last   = (r_cnt + LEN_W'(1)) == r_len[LEN_W-1:0];
                    // clear the byte just sent
                    o_wr.en      = r_raddr < BUF_X;
                    o_wr.addr    = r_raddr;
                    if (o_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + LEN_W'(1);
                        n_raddr = r_raddr + XW'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= vrb_pkg::START_RST;
            r_end   <= vrb_pkg::END_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vrb_pkg::CFG_START: r_start <= i_cfg_wdata[vrb_pkg::START_W-1:0];
                vrb_pkg::CFG_END:   r_end   <= i_cfg_wdata;
                default:            r_end   <= r_end;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_rpos  <= POS_W'(vrb_pkg::START_RST);
            r_wpos  <= POS_W'(vrb_pkg::START_RST);
            r_flag  <= 1'b1;
            r_left  <= '0;
            r_wacc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_rpos  <= n_rpos;
            r_wpos  <= n_wpos;
            r_flag  <= n_flag;
            r_left  <= n_left;
            r_wacc  <= n_wacc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_cnt    <= n_cnt;
        r_len    <= n_len;
        r_raddr  <= n_raddr;
        r_phase  <= n_phase;
        r_res_st <= n_res_st;
    end

endmodule

/* design/variable_record_ring_buffer.sv */
// ----------------------------------------------------------------------------
// variable_record_ring_buffer
// Ring store of length-prefixed records with a stream command input and a
// stream result output.
// ----------------------------------------------------------------------------
// After reset the block first zeroes the byte store, one byte a cycle, while
// s_axis_tready stays low; region registers can be written during that
// pass. Every word goes through one byte store with one write and one
// registered read port, and the sequencer handles one word at a time: a
// payload byte is written and then its result is sent, a write header writes
// its header bytes one by one before its result, and a read does the header
// fetch (done twice when the read wraps at a zero or overrunning header), a
// header clear of one byte a cycle, then one payload byte a cycle as long as
// m_axis_tready is high. Each word gives one result, except an unknown
// command, which gives none, and a read of a non-empty record, which gives one
// result per payload byte with tlast on the final one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module variable_record_ring_buffer #(
    parameter int BUFFER_BYTES     = vrb_pkg::BUFFER_BYTES_DEF,
    parameter int HEADER_BYTES     = vrb_pkg::HEADER_BYTES_DEF,
    parameter int MAX_RECORD_BYTES = vrb_pkg::MAX_RECORD_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vrb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vrb_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [6:0] record_length, [14:7] payload_byte, [15] zero
    input  logic [vrb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] command
    input  logic [vrb_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] data_byte
    output logic [vrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status, [2] data_valid
    output logic [vrb_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int IW = $clog2(BUFFER_BYTES);

    vrb_pkg::t_res              res;
    vrb_pkg::t_wr               wr;
    logic [IW-1:0]              raddr;
    logic [vrb_pkg::BYTE_W-1:0] rdata;
    logic                       out_free;

    vrb_ctrl #(
        .BUFFER_BYTES     (BUFFER_BYTES),
        .HEADER_BYTES     (HEADER_BYTES),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (vrb_pkg::t_cmd'(s_axis_tuser)),
        .i_len       (s_axis_tdata[6:0]),
        .i_byte      (s_axis_tdata[14:7]),
        .i_out_free  (out_free),
        .o_res       (res),
        .o_wr        (wr),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    vrb_mem #(
        .DEPTH (BUFFER_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    vrb_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (res),
        .i_tready (m_axis_tready),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

/* design/vrb_chk.sv */
// ----------------------------------------------------------------------------
// vrb_chk
// Port-level checks of the variable record ring buffer, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "variable_record_ring_buffer_assert.svh"

module vrb_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [vrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [vrb_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic                            m_axis_tlast
);

    // reset empties the output and starts the clearing pass
    `VRB_ASSERT_RST(a_rst_idle, i_clk, i_rst_n, !m_axis_tvalid && !s_axis_tready)

    // status-only results carry a zero data byte
    `VRB_ASSERT_NOW(a_nodata_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata == '0)

    // payload bytes only come with an ok status
    `VRB_ASSERT_NOW(a_data_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == vrb_pkg::ST_OK)

    // no new command while a record is still streaming out
    `VRB_ASSERT_NOW(a_busy_in_record, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    // stalled result word holds
    `VRB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

endmodule

bind variable_record_ring_buffer vrb_chk u_vrb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb - testbench of variable_record_ring_buffer
// Streams write-header, payload-byte, read-record and unknown commands into the ring
// buffer with random gaps, takes its result words with random back-pressure
// and one long hold-off, and checks every word against a shadow copy of the
// store, the read/write positions and the region registers kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int          HALF_PERIOD      = 5;
    localparam int          SETTLE_CYCLES    = 150;
    localparam int          TIMEOUT_NS       = 8_000_000;
    localparam int          HOLD_AT_WORD     = 120;
    localparam int          HOLD_CYCLES      = 1500;
    localparam int          MAX_PRINTS       = 50;
    localparam int          POS_MASK         = 'h1FFF;
    localparam int          LEN_W            = vrb_pkg::LEN_W;
    localparam int          BYTE_W           = vrb_pkg::BYTE_W;
    localparam int          BUFFER_BYTES_DEF = vrb_pkg::BUFFER_BYTES_DEF;
    localparam int          HEADER_BYTES_DEF = vrb_pkg::HEADER_BYTES_DEF;
    localparam int          MAX_RECORD_DEF   = vrb_pkg::MAX_RECORD_DEF;
    localparam logic [1:0]  CMD_NONE         = 2'd3;   // not decoded by the block

    typedef struct packed {
        logic [1:0]        cmd;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] pb;
    } t_cmd_word;

    typedef struct packed {
        vrb_pkg::t_status  status;
        logic [BYTE_W-1:0] data;
        logic              dvalid;
        logic              last;
    } t_reply;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [vrb_pkg::CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [vrb_pkg::CFG_DATA_W-1:0]     i_cfg_wdata = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [vrb_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;
    logic [vrb_pkg::IN_TUSER_W-1:0]     s_axis_tuser = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [vrb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic [vrb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser;
    logic                               m_axis_tlast;

    variable_record_ring_buffer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // shadow of the block
    logic [BYTE_W-1:0] shadow_mem [0:BUFFER_BYTES_DEF-1];
    int                reg_start, reg_end;
    int                rd_pos, wr_pos, owed_bytes;
    bit                writer_ahead, wr_open;

    t_cmd_word cmd_backlog [$];
    t_reply    replies_due [$];
    int        n_queued = 0, n_taken = 0, hdrs_queued = 0, err_count = 0;
    logic      in_fire = 1'b0, out_fire = 1'b0;

    int tx_gap = 0, rx_hold = 0, words_taken = 0;
    bit tx_burst = 1'b0, rx_burst = 1'b0, held_off = 1'b0;

    task automatic mismatch(input string what);
        if (err_count < MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    function automatic logic [BYTE_W-1:0] peek(input int a);
        return (a >= 0 && a < BUFFER_BYTES_DEF) ? shadow_mem[a] : 8'h00;
    endfunction

    function automatic void poke(input int a, input logic [BYTE_W-1:0] v);
        if (a >= 0 && a < BUFFER_BYTES_DEF)
            shadow_mem[a] = v;
    endfunction

    function automatic int stored_len(input int a);
        int n;
        n = peek(a);
        if (HEADER_BYTES_DEF >= 2)
            n = n | (int'(peek(a + 1)) << 8);
        return n;
    endfunction

    function automatic void owe_reply(input vrb_pkg::t_status st,
                                      input logic [BYTE_W-1:0] d,
                                      input logic dv, input logic lst);
        replies_due.push_back('{status: st, data: d, dvalid: dv, last: lst});
    endfunction

    // wrap the writer to the region start when the record would cross the end
    function automatic bit find_room(input int size);
        int w, r;
        w = wr_pos;
        r = rd_pos;
        if (w > r || (writer_ahead && w == r)) begin
            if (w + size <= reg_end)
                return 1'b1;
            wr_pos = reg_start;
            writer_ahead = !writer_ahead;
            w = wr_pos;
        end
        if (w < r)
            return (w + size <= r);
        return 1'b0;
    endfunction

    // wrap the reader at a zero or overrunning header
    function automatic bit find_record();
        int w, r, n;
        w = wr_pos;
        r = rd_pos;
        if (w < r || (!writer_ahead && w == r)) begin
            if (r + HEADER_BYTES_DEF < reg_end) begin
                n = stored_len(r);
                if (n > 0 && r + HEADER_BYTES_DEF + n <= reg_end)
                    return 1'b1;
            end
            rd_pos = reg_start;
            writer_ahead = !writer_ahead;
        end
        return (wr_pos > rd_pos);
    endfunction

    task automatic apply_command(input logic [1:0] cmd, input logic [LEN_W-1:0] len7,
                                 input logic [BYTE_W-1:0] pb);
        int len, r, n, a;
        len = len7;
        case (cmd)
            vrb_pkg::CMD_WHDR: begin
                wr_open = 1'b0;
                owed_bytes = 0;
                if (len == 0 || len > MAX_RECORD_DEF) begin
                    owe_reply(vrb_pkg::ST_BADLEN, 8'h00, 1'b0, 1'b1);
                end else if (!find_room(len + HEADER_BYTES_DEF)) begin
                    owe_reply(vrb_pkg::ST_NOSPACE, 8'h00, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < HEADER_BYTES_DEF; i++)
                        poke(wr_pos + i, (i == 0) ? 8'(len) : (i == 1) ? 8'(len >> 8) : 8'h00);
                    wr_pos = (wr_pos + HEADER_BYTES_DEF + len) & POS_MASK;
                    wr_open = 1'b1;
                    owed_bytes = len;
                    owe_reply(vrb_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
                end
            end
            vrb_pkg::CMD_WBYTE: begin
                if (!wr_open || owed_bytes == 0) begin
                    wr_open = 1'b0;
                    owed_bytes = 0;
                    owe_reply(vrb_pkg::ST_NOSPACE, 8'h00, 1'b0, 1'b1);
                end else begin
                    poke((wr_pos - owed_bytes) & POS_MASK, pb);
                    owed_bytes--;
                    if (owed_bytes == 0)
                        wr_open = 1'b0;
                    owe_reply(vrb_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
                end
            end
            vrb_pkg::CMD_READ: begin
                wr_open = 1'b0;
                owed_bytes = 0;
                if (!find_record()) begin
                    owe_reply(vrb_pkg::ST_EMPTY, 8'h00, 1'b0, 1'b1);
                end else begin
                    r = rd_pos;
                    n = stored_len(r);
                    if (n > MAX_RECORD_DEF) begin
                        owe_reply(vrb_pkg::ST_BADLEN, 8'h00, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < HEADER_BYTES_DEF; i++)
                            poke(r + i, 8'h00);
                        if (n == 0)
                            owe_reply(vrb_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
                        for (int i = 0; i < n; i++) begin
                            a = r + HEADER_BYTES_DEF + i;
                            owe_reply(vrb_pkg::ST_OK, peek(a), 1'b1, (i + 1 == n));
                            poke(a, 8'h00);
                        end
                        rd_pos = (r + HEADER_BYTES_DEF + n) & POS_MASK;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // sample both handshakes, predict from accepted commands, check results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            out_fire <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                n_taken = n_taken + 1;
                apply_command(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[14:7]);
            end
            if (m_axis_tvalid && m_axis_tready) begin : check_word
                t_reply due;
                if (replies_due.size() == 0) begin
                    mismatch("result word with nothing pending");
                end else begin
                    due = replies_due.pop_front();
                    if (m_axis_tuser[1:0] !== due.status)
                        mismatch($sformatf("status %0d, want %0d", m_axis_tuser[1:0],
                                           due.status));
                    if (m_axis_tdata !== due.data)
                        mismatch($sformatf("data %h, want %h", m_axis_tdata, due.data));
                    if (m_axis_tuser[2] !== due.dvalid)
                        mismatch($sformatf("data_valid %b, want %b", m_axis_tuser[2],
                                           due.dvalid));
                    if (m_axis_tlast !== due.last)
                        mismatch($sformatf("tlast %b, want %b", m_axis_tlast, due.last));
                end
            end
        end
    end

    // command driver: hold a word until taken, then wait its drawn gap
    always @(negedge i_clk) begin : drive_commands
        t_cmd_word nxt;
        if (i_rst_n && !(s_axis_tvalid && !in_fire)) begin
            if (s_axis_tvalid) begin
                if ($urandom_range(0, 19) == 0)
                    tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 18);
            end
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                nxt = cmd_backlog.pop_front();
                s_axis_tdata <= {1'b0, nxt.pb, nxt.len};
                s_axis_tuser <= nxt.cmd;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stall after each word, one long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                words_taken++;
                if ($urandom_range(0, 19) == 0)
                    rx_burst = !rx_burst;
                rx_hold = rx_burst ? 0 : $urandom_range(0, 18);
                if (!held_off && words_taken == HOLD_AT_WORD) begin
                    rx_hold = HOLD_CYCLES;
                    held_off = 1'b1;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic push_cmd(input logic [1:0] cmd, input int len, input logic [BYTE_W-1:0] pb);
        cmd_backlog.push_back('{cmd: cmd, len: 7'(len), pb: pb});
        n_queued++;
        if (cmd == vrb_pkg::CMD_WHDR)
            hdrs_queued++;
    endtask

    task automatic queue_record(input int len, input int sent);
        push_cmd(vrb_pkg::CMD_WHDR, len, 8'($urandom));
        repeat (sent) push_cmd(vrb_pkg::CMD_WBYTE, $urandom_range(0, 127), 8'($urandom));
    endtask

    // mostly short records, a few of the largest
    function automatic int pick_len();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return MAX_RECORD_DEF;
        if (k < 3)
            return $urandom_range(9, MAX_RECORD_DEF - 1);
        return $urandom_range(1, 8);
    endfunction

    task automatic random_traffic(input int count);
        int made, pick, len, sent;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = pick_len();
                queue_record(len, len);
                made += len + 1;
            end else if (pick < 80) begin
                push_cmd(vrb_pkg::CMD_READ, $urandom_range(0, 127), 8'($urandom));
                made++;
            end else if (pick < 85) begin
                // broken record: stop short of the length
                len = pick_len();
                sent = $urandom_range(0, len - 1);
                queue_record(len, sent);
                made += sent + 1;
            end else if (pick < 90) begin
                push_cmd(vrb_pkg::CMD_WHDR,
                         $urandom_range(0, 1) ? 0 : $urandom_range(65, 127),
                         8'($urandom));
                made++;
            end else if (pick < 95) begin
                push_cmd(vrb_pkg::CMD_WBYTE, $urandom_range(0, 127), 8'($urandom));
                made++;
            end else begin
                push_cmd(CMD_NONE, $urandom_range(0, 127), 8'($urandom));
            end
        end
    endtask

    task automatic settle();
        while (n_taken < n_queued || replies_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // read out what the phase left behind, then go idle
    task automatic flush_and_settle();
        repeat (hdrs_queued + 1) push_cmd(vrb_pkg::CMD_READ, 0, 8'h00);
        hdrs_queued = 0;
        settle();
    endtask

    task automatic config_write(input logic [vrb_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= 13'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == vrb_pkg::CFG_START)
            reg_start = value & 'hFFF;
        else
            reg_end = value & 'h1FFF;
    endtask

    task automatic set_region(input int first, input int stop);
        config_write(vrb_pkg::CFG_START, first);
        config_write(vrb_pkg::CFG_END, stop);
    endtask

    initial begin
        int edge_pos;
        foreach (shadow_mem[i])
            shadow_mem[i] = 8'h00;
        reg_start = vrb_pkg::START_RST;
        reg_end = vrb_pkg::END_RST;
        rd_pos = reg_start;
        wr_pos = reg_start;
        writer_ahead = 1'b1;
        owed_bytes = 0;
        wr_open = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // refusals, stray and unknown words
        push_cmd(vrb_pkg::CMD_READ, 0, 8'h00);
        push_cmd(vrb_pkg::CMD_WHDR, 0, 8'h00);
        push_cmd(vrb_pkg::CMD_WHDR, 127, 8'hFF);
        push_cmd(vrb_pkg::CMD_WHDR, MAX_RECORD_DEF + 1, 8'h00);
        push_cmd(vrb_pkg::CMD_WBYTE, 0, 8'hFF);
        push_cmd(CMD_NONE, 127, 8'hFF);
        // one-byte record
        push_cmd(vrb_pkg::CMD_WHDR, 1, 8'h00);
        push_cmd(vrb_pkg::CMD_WBYTE, 0, 8'h00);
        push_cmd(vrb_pkg::CMD_READ, 0, 8'h00);
        // header during pending payload abandons the older record
        push_cmd(vrb_pkg::CMD_WHDR, 3, 8'h00);
        push_cmd(vrb_pkg::CMD_WBYTE, 0, 8'h5A);
        push_cmd(vrb_pkg::CMD_WHDR, 2, 8'h00);
        push_cmd(vrb_pkg::CMD_WBYTE, 0, 8'hAA);
        push_cmd(vrb_pkg::CMD_WBYTE, 0, 8'h55);
        push_cmd(vrb_pkg::CMD_READ, 0, 8'h00);
        push_cmd(vrb_pkg::CMD_READ, 0, 8'h00);
        // read during pending payload cancels the write
        push_cmd(vrb_pkg::CMD_WHDR, 4, 8'h00);
        push_cmd(vrb_pkg::CMD_WBYTE, 0, 8'hC3);
        push_cmd(vrb_pkg::CMD_READ, 0, 8'h00);
        push_cmd(vrb_pkg::CMD_WBYTE, 0, 8'h11);
        // largest record, payload left as zeros
        push_cmd(vrb_pkg::CMD_WHDR, MAX_RECORD_DEF, 8'h00);
        push_cmd(vrb_pkg::CMD_READ, 0, 8'h00);
        random_traffic(25);
        flush_and_settle();

        // move the region under the reader: zero-length and oversized headers
        edge_pos = wr_pos;
        set_region(10, edge_pos + 1);
        push_cmd(vrb_pkg::CMD_WHDR, 3, 8'h00);
        push_cmd(vrb_pkg::CMD_WBYTE, 0, 8'h00);
        push_cmd(vrb_pkg::CMD_WBYTE, 0, 8'h9A);
        push_cmd(vrb_pkg::CMD_WBYTE, 0, 8'h77);
        settle();
        config_write(vrb_pkg::CFG_START, 11);
        push_cmd(vrb_pkg::CMD_READ, 0, 8'h00);
        push_cmd(vrb_pkg::CMD_READ, 0, 8'h00);
        settle();
        config_write(vrb_pkg::CFG_END, 16);
        push_cmd(vrb_pkg::CMD_WHDR, 1, 8'h00);
        push_cmd(vrb_pkg::CMD_READ, 0, 8'h00);
        settle();

        set_region(0, BUFFER_BYTES_DEF);
        random_traffic(20);
        flush_and_settle();

        // tight region so both positions wrap often
        set_region(16, (wr_pos + 90 > BUFFER_BYTES_DEF) ? BUFFER_BYTES_DEF : wr_pos + 90);
        random_traffic(20);
        flush_and_settle();

        set_region(4095, BUFFER_BYTES_DEF);
        random_traffic(8);
        flush_and_settle();

        set_region(1, 4095);
        random_traffic(12);
        flush_and_settle();

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* variable_record_ring_buffer.f */
+incdir+design
design/vrb_pkg.sv
design/vrb_mem.sv
design/vrb_out.sv
design/vrb_ctrl.sv
design/variable_record_ring_buffer.sv
design/vrb_chk.sv
sim/tb.sv
